// ----- design/sbe_pkg.sv -----
// Shared constants for the stack bytecode execute unit.
`timescale 1ns / 1ps
package sbe_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int LOCAL_COUNT = 256;

    localparam logic [4:0] OP_NOP   = 5'd0;
    localparam logic [4:0] OP_POP   = 5'd1;
    localparam logic [4:0] OP_DUP   = 5'd2;
    localparam logic [4:0] OP_SWAP  = 5'd3;
    localparam logic [4:0] OP_ADD   = 5'd4;
    localparam logic [4:0] OP_SUB   = 5'd5;
    localparam logic [4:0] OP_MUL   = 5'd6;
    localparam logic [4:0] OP_DIV   = 5'd7;
    localparam logic [4:0] OP_REM   = 5'd8;
    localparam logic [4:0] OP_AND   = 5'd9;
    localparam logic [4:0] OP_OR    = 5'd10;
    localparam logic [4:0] OP_XOR   = 5'd11;
    localparam logic [4:0] OP_SHL   = 5'd12;
    localparam logic [4:0] OP_SHR   = 5'd13;
    localparam logic [4:0] OP_BPUSH = 5'd14;
    localparam logic [4:0] OP_CPUSH = 5'd15;
    localparam logic [4:0] OP_VLOAD = 5'd16;
    localparam logic [4:0] OP_VSTOR = 5'd17;
    localparam logic [4:0] OP_IFEQ  = 5'd18;
    localparam logic [4:0] OP_IFNE  = 5'd19;
    localparam logic [4:0] OP_IFLT  = 5'd20;
    localparam logic [4:0] OP_IFGE  = 5'd21;
    localparam logic [4:0] OP_IFGT  = 5'd22;
    localparam logic [4:0] OP_IFLE  = 5'd23;
    localparam logic [4:0] OP_GOTO  = 5'd24;
    localparam logic [4:0] OP_RET   = 5'd25;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_DIV    = 3'd1;
    localparam logic [2:0] ERR_SHIFT  = 3'd2;
    localparam logic [2:0] ERR_UNDER  = 3'd3;
    localparam logic [2:0] ERR_OVER   = 3'd4;
    localparam logic [2:0] ERR_OPCODE = 3'd5;

    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0] SHIFT_MAX = 32'd31;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, start stack reads
        logic rd_x;      // capture second operand
        logic rd_y;      // capture top operand
        logic div_start;
        logic exec;      // check and compute, write back
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic need_div;
    } t_status;
endpackage

// ----- design/sbe_divider.sv -----
// Radix-2 restoring divider for signed 32-bit quotient and remainder.
`timescale 1ns / 1ps
module sbe_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic [31:0] r_q, r_d, r_r;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done, r_nq, r_nr;
    logic [32:0] n_trial;
    logic [31:0] n_rs;

    assign n_rs    = {r_r[30:0], r_q[31]};
    assign n_trial = {1'b0, n_rs} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_q    <= i_dividend[31] ? 32'(-i_dividend) : i_dividend;
                r_d    <= i_divisor[31] ? 32'(-i_divisor) : i_divisor;
                r_r    <= '0;
                r_nq   <= i_dividend[31] ^ i_divisor[31];
                r_nr   <= i_dividend[31];
            end else if (r_busy) begin
                if (n_trial[32]) begin
                    r_r <= n_rs;
                    r_q <= {r_q[30:0], 1'b0};
                end else begin
                    r_r <= n_trial[31:0];
                    r_q <= {r_q[30:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq ? 32'(-r_q) : r_q;
    assign o_rem  = r_nr ? 32'(-r_r) : r_r;
endmodule

// ----- design/sbe_datapath.sv -----
// Datapath: operand stack, local file, pc, arithmetic and result registers.
`timescale 1ns / 1ps
module sbe_datapath #(
    parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH,
    parameter int LOCAL_COUNT = sbe_pkg::LOCAL_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbe_pkg::t_cmd     i_cmd,
    output sbe_pkg::t_status  o_status,
    input  logic [4:0]        i_mode,
    input  logic [7:0]        i_byte_operand,
    input  logic [15:0]       i_branch_offset,
    input  logic [31:0]       i_pool_value,
    output logic [15:0]       o_next_pc,
    output logic [31:0]       o_top_value,
    output logic [6:0]        o_stack_count,
    output logic [31:0]       o_return_value,
    output logic              o_finished,
    output logic [2:0]        o_error_code
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LAW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

    logic [31:0] r_stack [STACK_DEPTH];
    logic [31:0] r_locals [LOCAL_COUNT];
    logic [LOCAL_COUNT-1:0] r_lvalid;

    logic [SPW-1:0] r_sp;
    logic [15:0]    r_pc;
    logic           r_halted;
    logic [2:0]     r_err;
    logic [31:0]    r_ret, r_top;

    logic [4:0]  r_mode;
    logic [7:0]  r_bop;
    logic [15:0] r_off;
    logic [31:0] r_pool;
    logic [31:0] r_x, r_y, r_rd, r_lrd;
    logic        r_lv;

    logic [1:0]  n_need, n_push;
    logic [31:0] n_r;
    logic        n_taken;
    logic [2:0]  n_err;
    logic [SPW:0] n_sp;
    logic [15:0] n_pc;
    logic [31:0] n_dq, n_dr;
    logic        n_ddone;
    logic        n_lidx_ok;

    assign n_lidx_ok = {24'd0, r_bop} < 32'(LOCAL_COUNT);

    sbe_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_x),
        .i_divisor  (r_y),
        .o_done     (n_ddone),
        .o_quot     (n_dq),
        .o_rem      (n_dr)
    );

    always_comb begin
        n_need = 2'd2;
        n_push = 2'd0;
        priority if (r_mode == sbe_pkg::OP_NOP || r_mode == sbe_pkg::OP_GOTO) begin
            n_need = 2'd0;
        end else if (r_mode == sbe_pkg::OP_POP || r_mode == sbe_pkg::OP_VSTOR ||
                     r_mode == sbe_pkg::OP_RET) begin
            n_need = 2'd1;
        end else if (r_mode == sbe_pkg::OP_DUP) begin
            n_need = 2'd1; n_push = 2'd2;
        end else if (r_mode == sbe_pkg::OP_SWAP) begin
            n_push = 2'd2;
        end else if (r_mode <= sbe_pkg::OP_SHR) begin
            n_push = 2'd1;
        end else if (r_mode <= sbe_pkg::OP_VLOAD) begin
            n_need = 2'd0; n_push = 2'd1;
        end else begin
            n_need = 2'd2;
        end
    end

    assign o_status.need_div = (r_mode == sbe_pkg::OP_DIV || r_mode == sbe_pkg::OP_REM) &&
                               r_sp >= SPW'(2) && r_y != 32'd0 &&
                               !(r_x == sbe_pkg::WORD_MIN && r_y == 32'hFFFF_FFFF);
    assign o_status.div_done = n_ddone;

    always_comb begin
        n_r = '0;
        n_taken = 1'b0;
        n_err = sbe_pkg::ERR_NONE;
        n_sp = {1'b0, r_sp} - (SPW+1)'(n_need) + (SPW+1)'(n_push);
        if (r_mode > sbe_pkg::OP_RET) n_err = sbe_pkg::ERR_OPCODE;
        else if (r_sp < SPW'(n_need)) n_err = sbe_pkg::ERR_UNDER;
        else if (n_sp > (SPW+1)'(STACK_DEPTH)) n_err = sbe_pkg::ERR_OVER;
        unique case (r_mode)
            sbe_pkg::OP_DIV, sbe_pkg::OP_REM: begin
                if (n_err == sbe_pkg::ERR_NONE &&
                    (r_y == 32'd0 || (r_x == sbe_pkg::WORD_MIN && r_y == 32'hFFFF_FFFF)))
                    n_err = sbe_pkg::ERR_DIV;
                n_r = (r_mode == sbe_pkg::OP_DIV) ? n_dq : n_dr;
            end
            sbe_pkg::OP_SHL, sbe_pkg::OP_SHR: begin
                if (n_err == sbe_pkg::ERR_NONE && r_y > sbe_pkg::SHIFT_MAX)
                    n_err = sbe_pkg::ERR_SHIFT;
                n_r = (r_mode == sbe_pkg::OP_SHL) ? (r_x << r_y[4:0])
                                                  : 32'($signed(r_x) >>> r_y[4:0]);
            end
            sbe_pkg::OP_ADD:   n_r = r_x + r_y;
            sbe_pkg::OP_SUB:   n_r = r_x - r_y;
            sbe_pkg::OP_MUL:   n_r = r_x * r_y;
            sbe_pkg::OP_AND:   n_r = r_x & r_y;
            sbe_pkg::OP_OR:    n_r = r_x | r_y;
            sbe_pkg::OP_XOR:   n_r = r_x ^ r_y;
            sbe_pkg::OP_BPUSH: n_r = {{24{r_bop[7]}}, r_bop};
            sbe_pkg::OP_CPUSH: n_r = r_pool;
            sbe_pkg::OP_VLOAD: n_r = (n_lidx_ok && r_lv) ? r_lrd : 32'd0;
            sbe_pkg::OP_IFEQ:  n_taken = r_x == r_y;
            sbe_pkg::OP_IFNE:  n_taken = r_x != r_y;
            sbe_pkg::OP_IFLT:  n_taken = $signed(r_x) <  $signed(r_y);
            sbe_pkg::OP_IFGE:  n_taken = $signed(r_x) >= $signed(r_y);
            sbe_pkg::OP_IFGT:  n_taken = $signed(r_x) >  $signed(r_y);
            sbe_pkg::OP_IFLE:  n_taken = $signed(r_x) <= $signed(r_y);
            sbe_pkg::OP_GOTO:  n_taken = 1'b1;
            default:           n_r = '0;
        endcase
        priority if (r_mode >= sbe_pkg::OP_IFEQ)
            n_pc = n_taken ? r_pc + r_off : r_pc + 16'd3;
        else if (r_mode == sbe_pkg::OP_CPUSH)
            n_pc = r_pc + 16'd3;
        else if (r_mode == sbe_pkg::OP_BPUSH || r_mode == sbe_pkg::OP_VLOAD ||
                 r_mode == sbe_pkg::OP_VSTOR)
            n_pc = r_pc + 16'd2;
        else
            n_pc = r_pc + 16'd1;
    end

    // stack and local memories; reads registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_bop  <= i_byte_operand;
            r_off  <= i_branch_offset;
            r_pool <= i_pool_value;
        end
        if (i_cmd.rd_y) begin
            r_y   <= r_rd;
            r_lrd <= r_locals[r_bop[LAW-1:0]];
            r_lv  <= r_lvalid[r_bop[LAW-1:0]];
        end
        if (i_cmd.rd_x) r_x <= r_rd;
        if (i_cmd.load)
            r_rd <= r_stack[SAW'(r_sp - SPW'(1))];
        else if (i_cmd.rd_y)
            r_rd <= r_stack[SAW'(r_sp - SPW'(2))];
        else if (i_cmd.rd_x)
            r_rd <= r_stack[SAW'(r_sp - SPW'(3))];
        if (i_cmd.exec && !r_halted && n_err == sbe_pkg::ERR_NONE) begin
            if (r_mode == sbe_pkg::OP_DUP)
                r_stack[SAW'(r_sp)] <= r_y;
            else if (r_mode == sbe_pkg::OP_SWAP) begin
                r_stack[SAW'(r_sp - SPW'(2))] <= r_y;
                r_stack[SAW'(r_sp - SPW'(1))] <= r_x;
            end else if (n_push == 2'd1)
                r_stack[SAW'(r_sp - SPW'(n_need))] <= n_r;
            if (r_mode == sbe_pkg::OP_VSTOR && n_lidx_ok)
                r_locals[r_bop[LAW-1:0]] <= r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0; r_pc <= '0; r_halted <= 1'b0; r_err <= '0;
            r_ret <= '0; r_top <= '0; r_lvalid <= '0;
        end else if (i_cmd.exec && !r_halted) begin
            if (n_err != sbe_pkg::ERR_NONE) begin
                r_err <= n_err;
                r_halted <= 1'b1;
            end else begin
                r_sp <= n_sp[SPW-1:0];
                if (r_mode == sbe_pkg::OP_VSTOR && n_lidx_ok)
                    r_lvalid[r_bop[LAW-1:0]] <= 1'b1;
                if (r_mode == sbe_pkg::OP_RET) begin
                    r_ret <= r_y;
                    r_halted <= 1'b1;
                end else begin
                    r_pc <= n_pc;
                end
                priority if (n_sp == '0) r_top <= '0;
                else if (r_mode == sbe_pkg::OP_DUP) r_top <= r_y;
                else if (r_mode == sbe_pkg::OP_SWAP) r_top <= r_x;
                else if (n_push == 2'd1) r_top <= n_r;
                else if (n_need == 2'd0) r_top <= r_y;
                else if (n_need == 2'd1) r_top <= r_x;
                else r_top <= r_rd;
            end
        end
    end

    // r_y holds entry sp-1, r_x entry sp-2; after rd_x r_rd holds entry sp-3
    assign o_next_pc      = r_pc;
    assign o_top_value    = r_top;
    assign o_stack_count  = 7'(r_sp);
    assign o_return_value = r_ret;
    assign o_finished     = r_halted;
    assign o_error_code   = r_err;
endmodule

// ----- design/sbe_control.sv -----
// Controller state machine sequencing stack reads, divide and write back.
`timescale 1ns / 1ps
module sbe_control (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_fire,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output sbe_pkg::t_cmd    o_cmd,
    input  sbe_pkg::t_status i_status
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDY  = 3'd1;
    localparam logic [2:0] S_RDX  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_EXEC = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_in_fire;
        unique case (r_state)
            S_IDLE: if (i_in_fire) n_state = S_RDY;
            S_RDY: begin o_cmd.rd_y = 1'b1; n_state = S_RDX; end
            S_RDX: begin
                o_cmd.rd_x = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_WAIT: if (i_status.div_done) n_state = S_EXEC;
            S_EXEC: begin o_cmd.exec = 1'b1; n_state = S_OUT; end
            S_OUT:  if (i_out_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule

// ----- design/stack_bytecode_execute_unit.sv -----
// Top level of the stack bytecode execute unit.
`timescale 1ns / 1ps
// One decoded instruction per request. After a request is accepted the block
// does three operand stack reads through one registered port, a check step,
// then execute and write back, and offers the result; the next request is
// taken the cycle after the result leaves. Divide and remainder with valid
// operands also wait for the bit-serial divider.
// Local variables read as zero until written, tracked by one valid bit per
// entry. After a return or an error the block repeats its final state until
// reset.
module stack_bytecode_execute_unit #(
    parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH,
    parameter int LOCAL_COUNT = sbe_pkg::LOCAL_COUNT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[4:0], byte_operand[12:5], branch_offset[28:13], pool_value[60:29]
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[15:0], top_value[47:16], stack_count[54:48],
    // return_value[86:55], finished[87], error_code[90:88]
    output logic [95:0]  m_axis_tdata
);
    sbe_pkg::t_cmd    w_cmd;
    sbe_pkg::t_status w_status;
    logic [15:0] w_pc;
    logic [31:0] w_top, w_ret;
    logic [6:0]  w_cnt;
    logic        w_fin;
    logic [2:0]  w_err;

    sbe_control u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (s_axis_tvalid && s_axis_tready),
        .i_out_fire (m_axis_tvalid && m_axis_tready),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    sbe_datapath #(
        .STACK_DEPTH(STACK_DEPTH),
        .LOCAL_COUNT(LOCAL_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_mode         (s_axis_tdata[4:0]),
        .i_byte_operand (s_axis_tdata[12:5]),
        .i_branch_offset(s_axis_tdata[28:13]),
        .i_pool_value   (s_axis_tdata[60:29]),
        .o_next_pc      (w_pc),
        .o_top_value    (w_top),
        .o_stack_count  (w_cnt),
        .o_return_value (w_ret),
        .o_finished     (w_fin),
        .o_error_code   (w_err)
    );

    assign m_axis_tdata = {5'd0, w_err, w_fin, w_ret, w_cnt, w_top, w_pc};
endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the stack bytecode execute unit.
`timescale 1ns / 1ps
module testbench;
    import sbe_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int RAND_ITEMS  = 2000;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [31:0] pool;
        logic [15:0] off;
        logic [7:0]  bop;
        logic [4:0]  mode;
    } insn_t;

    typedef struct packed {
        logic [2:0]  err;
        logic        fin;
        logic [31:0] retv;
        logic [6:0]  cnt;
        logic [31:0] top;
        logic [15:0] pc;
    } res_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    stack_bytecode_execute_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // machine copies: 0 generator, 1 checker, 2 scratch
    logic [31:0] stk   [3][STACK_DEPTH];
    logic [31:0] locv  [3][LOCAL_COUNT];
    int          sp    [3];
    logic [15:0] pcr   [3];
    logic        hlt   [3];
    logic [2:0]  serr  [3];
    logic [31:0] retv  [3];

    insn_t pending_q[$];
    res_t  expected_q[$];

    int    cyc, n_in, n_out, fails, stall, hold_cnt;
    bit    in_acc, out_acc, rst_done, hold_done;
    string halt_kind;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic res_t snap(int id);
        res_t s;
        s.pc   = pcr[id];
        s.top  = (sp[id] > 0) ? stk[id][sp[id] - 1] : 32'd0;
        s.cnt  = sp[id][6:0];
        s.retv = retv[id];
        s.fin  = hlt[id];
        s.err  = serr[id];
        return s;
    endfunction

    function automatic res_t exec_insn(int id, insn_t q);
        int          need, push, sx, sy;
        logic [31:0] x, y, r;
        logic        taken;
        logic [2:0]  fault;
        x = 0; y = 0; r = 0; taken = 0; fault = ERR_NONE; need = 0; push = 0;
        if (hlt[id]) return snap(id);
        if (q.mode > OP_RET) begin
            fault = ERR_OPCODE;
        end else begin
            if (q.mode == OP_NOP || q.mode == OP_GOTO) begin
                need = 0; push = 0;
            end else if (q.mode == OP_POP || q.mode == OP_VSTOR || q.mode == OP_RET) begin
                need = 1; push = 0;
            end else if (q.mode == OP_DUP) begin
                need = 1; push = 2;
            end else if (q.mode == OP_SWAP) begin
                need = 2; push = 2;
            end else if (q.mode <= OP_SHR) begin
                need = 2; push = 1;
            end else if (q.mode <= OP_VLOAD) begin
                need = 0; push = 1;
            end else begin
                need = 2; push = 0;
            end
            if (sp[id] < need) fault = ERR_UNDER;
            else if (sp[id] - need + push > STACK_DEPTH) fault = ERR_OVER;
            else begin
                if (need >= 1) y = stk[id][sp[id] - 1];
                if (need >= 2) x = stk[id][sp[id] - 2];
                sx = x; sy = y;
                case (q.mode)
                    OP_DIV, OP_REM: begin
                        if (y == 0 || (x == WORD_MIN && y == 32'hffff_ffff)) fault = ERR_DIV;
                        else r = (q.mode == OP_DIV) ? sx / sy : sx % sy;
                    end
                    OP_SHL, OP_SHR: begin
                        if (y > SHIFT_MAX) fault = ERR_SHIFT;
                        else if (q.mode == OP_SHL) r = x << y[4:0];
                        else r = $signed(x) >>> y[4:0];
                    end
                    OP_ADD:   r = x + y;
                    OP_SUB:   r = x - y;
                    OP_MUL:   r = x * y;
                    OP_AND:   r = x & y;
                    OP_OR:    r = x | y;
                    OP_XOR:   r = x ^ y;
                    OP_BPUSH: r = {{24{q.bop[7]}}, q.bop};
                    OP_CPUSH: r = q.pool;
                    OP_VLOAD: r = (q.bop < LOCAL_COUNT) ? locv[id][q.bop] : 32'd0;
                    OP_IFEQ:  taken = (x == y);
                    OP_IFNE:  taken = (x != y);
                    OP_IFLT:  taken = (sx < sy);
                    OP_IFGE:  taken = (sx >= sy);
                    OP_IFGT:  taken = (sx > sy);
                    OP_IFLE:  taken = (sx <= sy);
                    OP_GOTO:  taken = 1'b1;
                    default: ;
                endcase
            end
        end
        if (fault != ERR_NONE) begin
            serr[id] = fault;
            hlt[id]  = 1'b1;
            return snap(id);
        end
        if (q.mode == OP_VSTOR && q.bop < LOCAL_COUNT) locv[id][q.bop] = y;
        sp[id] -= need;
        if (q.mode == OP_DUP) begin
            stk[id][sp[id]] = y; stk[id][sp[id] + 1] = y;
        end else if (q.mode == OP_SWAP) begin
            stk[id][sp[id]] = y; stk[id][sp[id] + 1] = x;
        end else if (push == 1) begin
            stk[id][sp[id]] = r;
        end
        sp[id] += push;
        if (q.mode == OP_RET) begin
            retv[id] = y;
            hlt[id]  = 1'b1;
        end else if (q.mode >= OP_IFEQ) pcr[id] = taken ? pcr[id] + q.off : pcr[id] + 16'd3;
        else if (q.mode == OP_CPUSH) pcr[id] = pcr[id] + 16'd3;
        else if (q.mode == OP_BPUSH || q.mode == OP_VLOAD || q.mode == OP_VSTOR)
            pcr[id] = pcr[id] + 16'd2;
        else pcr[id] = pcr[id] + 16'd1;
        return snap(id);
    endfunction

    function automatic insn_t mk(logic [4:0] m, logic [7:0] b, logic [15:0] o, logic [31:0] p);
        insn_t q;
        q.mode = m; q.bop = b; q.off = o; q.pool = p;
        return q;
    endfunction

    task automatic machine_clear(int id);
        for (int i = 0; i < STACK_DEPTH; i++) stk[id][i] = 0;
        for (int i = 0; i < LOCAL_COUNT; i++) locv[id][i] = 0;
        sp[id] = 0; pcr[id] = 0; hlt[id] = 0; serr[id] = ERR_NONE; retv[id] = 0;
    endtask

    task automatic add_item(insn_t q);
        void'(exec_insn(0, q));
        pending_q.push_back(q);
    endtask

    // commit only requests that keep the program running
    task automatic try_item(insn_t q, output bit ok);
        res_t d;
        for (int i = 0; i < STACK_DEPTH; i++) stk[2][i] = stk[0][i];
        for (int i = 0; i < LOCAL_COUNT; i++) locv[2][i] = locv[0][i];
        sp[2] = sp[0]; pcr[2] = pcr[0]; hlt[2] = hlt[0]; serr[2] = serr[0];
        retv[2] = retv[0];
        d = exec_insn(2, q);
        ok = !d.fin;
        if (ok) add_item(q);
    endtask

    task automatic chk(string nm, logic [31:0] ev, logic [31:0] av);
        if (ev !== av) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, nm, ev, av);
            fails++;
        end
    endtask

    function automatic bit noisy();
        return !(cyc >= 2000 && cyc < 5000);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (rst_done && (!s_axis_tvalid || in_acc)) begin
            if (pending_q.size() > 0 && !(noisy() && $urandom_range(0, 99) < 7)) begin
                s_axis_tdata  <= {3'b0, pending_q.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with one long hold-off
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && n_in >= 600) begin
            hold_done = 1'b1;
            hold_cnt  = 400;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(noisy() && $urandom_range(0, 99) < 7);
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        res_t e, a;
        cyc++;
        in_acc  = rst_done && s_axis_tvalid && s_axis_tready;
        out_acc = rst_done && m_axis_tvalid && m_axis_tready;
        if (in_acc) begin
            expected_q.push_back(exec_insn(1, insn_t'(s_axis_tdata[60:0])));
            n_in++;
        end
        if (out_acc) begin
            a = res_t'(m_axis_tdata[90:0]);
            n_out++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %h", $time, a);
                fails++;
            end else begin
                e = expected_q.pop_front();
                chk("next_pc", e.pc, a.pc);
                chk("top_value", e.top, a.top);
                chk("stack_count", e.cnt, a.cnt);
                chk("return_value", e.retv, a.retv);
                chk("finished", e.fin, a.fin);
                chk("error_code", e.err, a.err);
            end
        end
        if (rst_done) begin
            stall = (in_acc || out_acc) ? 0 : stall + 1;
            if (stall >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, stall);
                $display("** stack_bytecode_execute_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        insn_t q;
        bit    ok;
        int    n, pushy;
        logic [4:0] m;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cyc = 0; n_in = 0; n_out = 0; fails = 0; stall = 0; hold_cnt = 0;
        in_acc = 0; out_acc = 0; rst_done = 0; hold_done = 0;
        machine_clear(0);
        machine_clear(1);

        // directed: extremes, a mix of operations, unwritten local, far index
        try_item(mk(OP_NOP, 8'h00, 16'h0000, 32'h0), ok);
        try_item(mk(OP_BPUSH, 8'h7f, 16'hffff, 32'hffff_ffff), ok);
        try_item(mk(OP_BPUSH, 8'h80, 16'h0, 32'h0), ok);
        try_item(mk(OP_CPUSH, 8'hff, 16'h0, WORD_MIN), ok);
        try_item(mk(OP_CPUSH, 8'h00, 16'h0, 32'h7fff_ffff), ok);
        try_item(mk(OP_ADD, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_DUP, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_MUL, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_SWAP, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_SUB, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_BPUSH, 8'd31, 16'h0, 32'h0), ok);
        try_item(mk(OP_SHR, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_BPUSH, 8'd31, 16'h0, 32'h0), ok);
        try_item(mk(OP_SHL, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_BPUSH, 8'hf9, 16'h0, 32'h0), ok);
        try_item(mk(OP_REM, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_VSTOR, 8'hff, 16'h0, 32'h0), ok);
        try_item(mk(OP_VLOAD, 8'hff, 16'h0, 32'h0), ok);
        try_item(mk(OP_VLOAD, 8'h07, 16'h0, 32'h0), ok);
        try_item(mk(OP_DIV, 8'h0, 16'h0, 32'h0), ok);
        try_item(mk(OP_BPUSH, 8'h05, 16'h0, 32'h0), ok);
        try_item(mk(OP_IFLT, 8'h0, 16'h8000, 32'h0), ok);
        try_item(mk(OP_GOTO, 8'h0, 16'h7fff, 32'h0), ok);
        try_item(mk(OP_POP, 8'h0, 16'h0, 32'h0), ok);

        // random programs that stay running; phases lean toward push or pop
        n = 0;
        pushy = 50;
        while (n < RAND_ITEMS) begin
            if (n % 200 == 0) pushy = $urandom_range(10, 90);
            q = mk(5'($urandom_range(0, 31)), 8'($urandom), 16'($urandom), $urandom);
            if ($urandom_range(0, 99) < pushy) begin
                case ($urandom_range(0, 4))
                    0: m = OP_BPUSH;
                    1: m = OP_CPUSH;
                    2: m = OP_VLOAD;
                    3: m = OP_DUP;
                    default: begin
                        m = OP_BPUSH;
                        q.bop = 8'($urandom_range(0, 31));
                    end
                endcase
            end else begin
                m = 5'($urandom_range(OP_NOP, OP_GOTO));
            end
            q.mode = m;
            try_item(q, ok);
            if (ok) n++;
        end

        // one halting case per run, picked by the seed
        case ($urandom_range(0, 6))
            0: begin
                halt_kind = "return";
                if (sp[0] == 0) add_item(mk(OP_CPUSH, 8'h0, 16'h0, $urandom));
                add_item(mk(OP_RET, 8'($urandom), 16'($urandom), $urandom));
            end
            1: begin
                halt_kind = "divide by zero";
                while (sp[0] > 60) add_item(mk(OP_POP, 8'h0, 16'h0, 32'h0));
                add_item(mk(OP_CPUSH, 8'h0, 16'h0, $urandom));
                add_item(mk(OP_BPUSH, 8'h00, 16'h0, 32'h0));
                add_item(mk($urandom_range(0, 1) ? OP_DIV : OP_REM, 8'h0, 16'h0, 32'h0));
            end
            2: begin
                halt_kind = "minimum over minus one";
                while (sp[0] > 60) add_item(mk(OP_POP, 8'h0, 16'h0, 32'h0));
                add_item(mk(OP_CPUSH, 8'h0, 16'h0, WORD_MIN));
                add_item(mk(OP_BPUSH, 8'hff, 16'h0, 32'h0));
                add_item(mk($urandom_range(0, 1) ? OP_DIV : OP_REM, 8'h0, 16'h0, 32'h0));
            end
            3: begin
                halt_kind = "shift out of range";
                while (sp[0] > 60) add_item(mk(OP_POP, 8'h0, 16'h0, 32'h0));
                add_item(mk(OP_CPUSH, 8'h0, 16'h0, $urandom));
                add_item(mk(OP_BPUSH, 8'($urandom_range(32, 255)), 16'h0, 32'h0));
                add_item(mk($urandom_range(0, 1) ? OP_SHL : OP_SHR, 8'h0, 16'h0, 32'h0));
            end
            4: begin
                halt_kind = "underflow";
                while (sp[0] > 0) add_item(mk(OP_POP, 8'h0, 16'h0, 32'h0));
                add_item(mk($urandom_range(0, 1) ? OP_POP : OP_ADD, 8'h0, 16'h0, 32'h0));
            end
            5: begin
                halt_kind = "overflow";
                if (sp[0] == 0) add_item(mk(OP_BPUSH, 8'($urandom), 16'h0, 32'h0));
                while (sp[0] < STACK_DEPTH) add_item(mk(OP_DUP, 8'h0, 16'h0, 32'h0));
                add_item(mk(OP_DUP, 8'h0, 16'h0, 32'h0));
            end
            default: begin
                halt_kind = "bad opcode";
                add_item(mk(5'($urandom_range(OP_RET + 1, 31)), 8'($urandom),
                            16'($urandom), $urandom));
            end
        endcase
        // halted: anything after must repeat the final state
        for (int i = 0; i < 8; i++)
            add_item(mk(5'($urandom_range(0, 31)), 8'($urandom), 16'($urandom), $urandom));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (expected_q.size() > 0) begin
            $display("%0t: %0d results never arrived", $time, expected_q.size());
            fails++;
        end
        $display("Ran %0d requests (%0d results checked) of random stack programs,", n_in, n_out);
        $display("ending with a halt by %s, then repeated requests while halted.", halt_kind);
        if (fails == 0) begin
            $display("** stack_bytecode_execute_unit: PASSED **");
        end else begin
            $display("** stack_bytecode_execute_unit: FAILED **");
        end
        $finish;
    end
endmodule
